@@ rtl/episode_replay_ring_buffer_assert.svh @@
// Assertion macros for the episode replay ring buffer checker.
`ifndef EPISODE_REPLAY_RING_BUFFER_ASSERT_SVH
`define EPISODE_REPLAY_RING_BUFFER_ASSERT_SVH
// Hold: a stalled beat keeps valid high and the payload unchanged.
`define ERRB_ASSERT_HOLD(label, clk, rst_n, vld, rdy, pay) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(vld && !rdy) |=> (vld && $stable(pay))) else $error("beat dropped or changed");
// Implication checked in the next cycle.
`define ERRB_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("sequence check failed");
// Implication checked in the same cycle.
`define ERRB_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("relation check failed");
`endif

@@ rtl/errb_pkg.sv @@
// ---------------------------------------------------------------------------
// errb_pkg: types and constants of the episode replay ring buffer
// Sizes, register indexes, opcodes and beat payload structs.
// ---------------------------------------------------------------------------
`default_nettype none
package errb_pkg;
	localparam int AGENTS      = 16;
	localparam int MAX_STEPS   = 256;
	localparam int EPISODES    = 64;
	localparam int RECORD_BITS = 64;
	localparam int AW = $clog2(AGENTS);
	localparam int SW = $clog2(MAX_STEPS);
	localparam int EW = $clog2(EPISODES);
	localparam int LW = SW + 1;
	localparam int FW = EW + 1;
	localparam int DW = RECORD_BITS + 8;

	localparam logic [1:0] REG_MAX_STEPS = 2'd0;
	localparam logic [1:0] REG_SLOTS     = 2'd1;
	localparam logic [1:0] REG_MIN_READY = 2'd2;
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  agent;
		logic [63:0] step_record;
		logic [7:0]  action;
		logic        done_req;
		logic [5:0]  episode_slot;
		logic [7:0]  step_index;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] read_record;
		logic [7:0]  read_action;
		logic [8:0]  read_length;
		logic [3:0]  read_agent;
		logic        flushed;
		logic [5:0]  flushed_slot;
		logic [6:0]  episodes_filled;
		logic        ready_res;
	} out_beat_t;
endpackage
`default_nettype wire

@@ rtl/errb_ram.sv @@
// ---------------------------------------------------------------------------
// errb_ram: single-port-write, single-port-read synchronous memory
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module errb_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/episode_replay_ring_buffer.sv @@
// ---------------------------------------------------------------------------
// episode_replay_ring_buffer: per-agent step stores feeding an episode ring
// Push, commit-copy and read sequencer around two step memories.
// ---------------------------------------------------------------------------
// One beat at a time, as in_ready is high only in idle. A push without a
// commit passes the push and done states, a read the read and done states
// (the read state covers the synchronous memory read); done returns to idle.
// A push that closes an episode of L >= 2 stored steps copies one step per
// cycle from the agent store into the ring memory in the copy state, between
// push and done, over the single read port of the agent store. Step counters
// (16), slot lengths and agents (64) live in flip-flops that reset clears;
// the step memories are never cleared, since every read is bounded by a
// stored length. The result register parts the sides: the next beat is
// taken while a result waits.
`default_nettype none
module episode_replay_ring_buffer (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [8:0]                cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire errb_pkg::in_beat_t        in_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output errb_pkg::out_beat_t            out_data
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PUSH = 3'd1;
	localparam logic [2:0] ST_COPY = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [8:0] max_steps_q;
	logic [6:0] slots_q;
	logic [6:0] min_ready_q;
	logic [errb_pkg::LW-1:0] cnt_q [errb_pkg::AGENTS];
	logic [errb_pkg::LW-1:0] len_q [errb_pkg::EPISODES];
	logic [errb_pkg::AW-1:0] own_q [errb_pkg::EPISODES];
	logic [errb_pkg::EW-1:0] head_q;
	logic [errb_pkg::FW-1:0] filled_q;
	errb_pkg::in_beat_t      beat_q;
	logic [errb_pkg::LW-1:0] clen_q;
	logic [errb_pkg::LW-1:0] cidx_q;
	logic                    flushed_q;
	logic [errb_pkg::EW-1:0] fslot_q;
	logic                    rd_hit_q;
	logic [errb_pkg::LW-1:0] rd_len_q;
	logic [errb_pkg::AW-1:0] rd_own_q;
	errb_pkg::out_beat_t     res_q;
	logic                    res_vld_q;

	// Clamp the limits as the register decode defines them.
	logic [errb_pkg::LW-1:0] step_lim;
	logic [errb_pkg::FW-1:0] slot_lim;
	always_comb begin
		step_lim = (max_steps_q > 9'(errb_pkg::MAX_STEPS)) ?
			errb_pkg::LW'(errb_pkg::MAX_STEPS) : errb_pkg::LW'(max_steps_q);
		if (slots_q == 7'd0) slot_lim = errb_pkg::FW'(1);
		else if (slots_q > 7'(errb_pkg::EPISODES)) slot_lim = errb_pkg::FW'(errb_pkg::EPISODES);
		else slot_lim = errb_pkg::FW'(slots_q);
	end

	wire logic accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	wire logic out_free = !res_vld_q || out_ready;
	wire logic [errb_pkg::AW-1:0] agt = beat_q.agent[errb_pkg::AW-1:0];
	wire logic [errb_pkg::LW-1:0] cur = cnt_q[agt];
	wire logic agt_ok = (5'(beat_q.agent) < 5'(errb_pkg::AGENTS));

	// Agent store: address = agent * MAX_STEPS + step.
	logic                                    as_we;
	logic [errb_pkg::AW+errb_pkg::SW-1:0]    as_waddr;
	logic [errb_pkg::AW+errb_pkg::SW-1:0]    as_raddr;
	logic [errb_pkg::DW-1:0]                 as_rdata;
	logic                                    rg_we;
	logic [errb_pkg::EW+errb_pkg::SW-1:0]    rg_waddr;
	logic [errb_pkg::EW+errb_pkg::SW-1:0]    rg_raddr;
	logic [errb_pkg::DW-1:0]                 rg_rdata;

	assign as_we    = (state_q == ST_PUSH) && agt_ok && (cur < step_lim);
	assign as_waddr = {agt, cur[errb_pkg::SW-1:0]};
	assign as_raddr = {agt, cidx_q[errb_pkg::SW-1:0]};
	// Step cidx-1 arrives from the agent store while step cidx is addressed.
	assign rg_we    = (state_q == ST_COPY) && (cidx_q != '0);
	assign rg_waddr = {head_q, errb_pkg::SW'(cidx_q - 1'b1)};
	assign rg_raddr = {beat_q.episode_slot[errb_pkg::EW-1:0], beat_q.step_index[errb_pkg::SW-1:0]};

	errb_ram #(.WIDTH(errb_pkg::DW), .DEPTH(errb_pkg::AGENTS * errb_pkg::MAX_STEPS)) u_agent_ram (
		.clk(clk), .we(as_we), .waddr(as_waddr),
		.wdata({beat_q.step_record[errb_pkg::RECORD_BITS-1:0], beat_q.action}),
		.raddr(as_raddr), .rdata(as_rdata)
	);
	errb_ram #(.WIDTH(errb_pkg::DW), .DEPTH(errb_pkg::EPISODES * errb_pkg::MAX_STEPS)) u_ring_ram (
		.clk(clk), .we(rg_we), .waddr(rg_waddr), .wdata(as_rdata),
		.raddr(rg_raddr), .rdata(rg_rdata)
	);

	// Length after this push, before the done flag clears the counter.
	wire logic [errb_pkg::LW-1:0] new_len = as_we ? cur + 1'b1 : cur;
	wire logic [errb_pkg::EW:0]   head_inc = {1'b0, head_q} + 1'b1;
	wire logic [errb_pkg::FW-1:0] fill_inc = filled_q + 1'b1;
	wire logic copy_last = (cidx_q == clen_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_steps_q <= 9'd256;
			slots_q     <= 7'd64;
			min_ready_q <= 7'd1;
			for (int i = 0; i < errb_pkg::AGENTS; i++) cnt_q[i] <= '0;
			for (int i = 0; i < errb_pkg::EPISODES; i++) begin
				len_q[i] <= '0;
				own_q[i] <= '0;
			end
			head_q    <= '0;
			filled_q  <= '0;
			clen_q    <= '0;
			cidx_q    <= '0;
			flushed_q <= 1'b0;
			fslot_q   <= '0;
			rd_hit_q  <= 1'b0;
			rd_len_q  <= '0;
			rd_own_q  <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					errb_pkg::REG_MAX_STEPS: max_steps_q <= cfg_data;
					errb_pkg::REG_SLOTS:     slots_q <= cfg_data[6:0];
					errb_pkg::REG_MIN_READY: min_ready_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			// Raise valid as a result is loaded, drop it once taken.
			if (state_q == ST_DONE && out_free) res_vld_q <= 1'b1;
			else if (res_vld_q && out_ready) res_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (in_data.opcode == errb_pkg::OP_PUSH) ? ST_PUSH : ST_READ;
					end
				end
				ST_PUSH: begin
					flushed_q <= 1'b0;
					fslot_q   <= '0;
					if (agt_ok) cnt_q[agt] <= beat_q.done_req ? '0 : new_len;
					if (agt_ok && beat_q.done_req && new_len >= errb_pkg::LW'(2)) begin
						// Copy: read step cidx, write step cidx-1 in the same cycle.
						clen_q  <= new_len;
						cidx_q  <= '0;
						state_q <= ST_COPY;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_COPY: begin
					cidx_q <= cidx_q + 1'b1;
					if (copy_last) begin
						len_q[head_q] <= clen_q;
						own_q[head_q] <= agt;
						flushed_q <= 1'b1;
						fslot_q   <= head_q;
						state_q   <= ST_DONE;
					end
				end
				ST_READ: begin
					flushed_q <= 1'b0;
					rd_len_q  <= len_q[beat_q.episode_slot[errb_pkg::EW-1:0]];
					rd_own_q  <= own_q[beat_q.episode_slot[errb_pkg::EW-1:0]];
					rd_hit_q  <= (errb_pkg::LW'(beat_q.step_index) <
						len_q[beat_q.episode_slot[errb_pkg::EW-1:0]]);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Advance head after the last ring write has landed.
					if (out_free) begin
						if (flushed_q) begin
							head_q   <= (errb_pkg::FW'(head_inc) >= slot_lim) ? '0 :
								head_inc[errb_pkg::EW-1:0];
							filled_q <= (fill_inc >= slot_lim) ? slot_lim : fill_inc;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Assemble the result beat.
	logic [errb_pkg::FW-1:0] fill_nx;
	always_comb begin
		fill_nx = filled_q;
		if (flushed_q) fill_nx = (fill_inc >= slot_lim) ? slot_lim : fill_inc;
	end

	errb_pkg::out_beat_t res_nx;
	always_comb begin
		res_nx = '0;
		if (beat_q.opcode == errb_pkg::OP_READ) begin
			res_nx.read_length = 9'(rd_len_q);
			res_nx.read_agent  = 4'(rd_own_q);
			if (rd_hit_q) begin
				res_nx.read_record = 64'(rg_rdata[errb_pkg::DW-1:8]);
				res_nx.read_action = rg_rdata[7:0];
			end
		end else begin
			res_nx.flushed      = flushed_q;
			res_nx.flushed_slot = 6'(fslot_q);
		end
		res_nx.episodes_filled = 7'(fill_nx);
		res_nx.ready_res = (7'(fill_nx) >= min_ready_q);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) beat_q <= in_data;
		if (state_q == ST_DONE && out_free) res_q <= res_nx;
	end

	assign out_valid = res_vld_q;
	assign out_data  = res_q;
endmodule
`default_nettype wire

@@ rtl/errb_checker.sv @@
// ---------------------------------------------------------------------------
// errb_checker: port-level checks of the episode replay ring buffer
// Handshake and result consistency seen at the top-level ports.
// ---------------------------------------------------------------------------
`default_nettype none
`include "episode_replay_ring_buffer_assert.svh"
module errb_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire errb_pkg::out_beat_t out_data
);
	`ERRB_ASSERT_HOLD(a_out_hold, clk, arst_n, out_valid, out_ready, out_data)
	`ERRB_ASSERT_NOW(a_flush_no_read, clk, arst_n, out_valid && out_data.flushed, out_data.read_length == 9'd0)
	`ERRB_ASSERT_NOW(a_fill_range, clk, arst_n, out_valid, out_data.episodes_filled <= 7'd64)
	`ERRB_ASSERT_NEXT(a_one_beat, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule
bind episode_replay_ring_buffer errb_checker u_errb_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

@@ test/tb.sv @@
// ---------------------------------------------------------------------------
// tb: episode replay ring buffer testbench
// Drives pushes and reads with random idling on both sides. A scoreboard
// predicts each result beat from its own copy of the agent stores and ring.
// ---------------------------------------------------------------------------
`default_nettype none

class replay_scoreboard;
	// predicted state
	logic [63:0] agent_rec [16][256];
	logic [7:0]  agent_act [16][256];
	int unsigned agent_cnt [16];
	logic [63:0] ring_rec [64][256];
	logic [7:0]  ring_act [64][256];
	int unsigned ring_len [64];
	int unsigned ring_who [64];
	int unsigned head;
	int unsigned filled;
	int unsigned step_cap;
	int unsigned slot_cfg;
	int unsigned ready_min;
	errb_pkg::out_beat_t pending_results[$];
	int errors;

	function new();
		foreach (agent_cnt[i]) agent_cnt[i] = 0;
		foreach (ring_len[i]) begin
			ring_len[i] = 0;
			ring_who[i] = 0;
		end
		head = 0;
		filled = 0;
		step_cap = 256;
		slot_cfg = 64;
		ready_min = 1;
		errors = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [8:0] val);
		case (idx)
			errb_pkg::REG_MAX_STEPS: step_cap = 32'(val);
			errb_pkg::REG_SLOTS:     slot_cfg = 32'(val[6:0]);
			errb_pkg::REG_MIN_READY: ready_min = 32'(val[6:0]);
			default: ;
		endcase
	endfunction

	// Note an accepted input beat and queue its predicted result.
	function void note_beat(errb_pkg::in_beat_t b);
		errb_pkg::out_beat_t r;
		int unsigned s, lim, slots, len;
		r = '0;
		if (b.opcode == errb_pkg::OP_PUSH) begin
			s = agent_cnt[b.agent];
			lim = (step_cap > 256) ? 256 : step_cap;
			if (s < lim) begin
				agent_rec[b.agent][s] = b.step_record;
				agent_act[b.agent][s] = b.action;
				agent_cnt[b.agent] = s + 1;
			end
			if (b.done_req) begin
				len = agent_cnt[b.agent];
				slots = (slot_cfg == 0) ? 1 : (slot_cfg > 64 ? 64 : slot_cfg);
				if (len >= 2) begin
					for (int i = 0; i < len; i++) begin
						ring_rec[head][i] = agent_rec[b.agent][i];
						ring_act[head][i] = agent_act[b.agent][i];
					end
					ring_len[head] = len;
					ring_who[head] = 32'(b.agent);
					r.flushed = 1'b1;
					r.flushed_slot = 6'(head);
					head = (head + 1 >= slots) ? 0 : head + 1;
					filled = (filled + 1 >= slots) ? slots : filled + 1;
				end
				agent_cnt[b.agent] = 0;
			end
		end else begin
			r.read_length = 9'(ring_len[b.episode_slot]);
			r.read_agent = 4'(ring_who[b.episode_slot]);
			if (b.step_index < ring_len[b.episode_slot]) begin
				r.read_record = ring_rec[b.episode_slot][b.step_index];
				r.read_action = ring_act[b.episode_slot][b.step_index];
			end
		end
		r.episodes_filled = 7'(filled);
		r.ready_res = (filled >= ready_min);
		pending_results.push_back(r);
	endfunction

	function void check_result(errb_pkg::out_beat_t got);
		errb_pkg::out_beat_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result beat %h", $realtime, got);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		if (got.read_record !== want.read_record)
			report("read_record", want.read_record, got.read_record);
		if (got.read_action !== want.read_action)
			report("read_action", 64'(want.read_action), 64'(got.read_action));
		if (got.read_length !== want.read_length)
			report("read_length", 64'(want.read_length), 64'(got.read_length));
		if (got.read_agent !== want.read_agent)
			report("read_agent", 64'(want.read_agent), 64'(got.read_agent));
		if (got.flushed !== want.flushed)
			report("flushed", 64'(want.flushed), 64'(got.flushed));
		if (got.flushed_slot !== want.flushed_slot)
			report("flushed_slot", 64'(want.flushed_slot), 64'(got.flushed_slot));
		if (got.episodes_filled !== want.episodes_filled)
			report("episodes_filled", 64'(want.episodes_filled), 64'(got.episodes_filled));
		if (got.ready_res !== want.ready_res)
			report("ready_res", 64'(want.ready_res), 64'(got.ready_res));
	endfunction

	function void report(string field, logic [63:0] want, logic [63:0] got);
		$display("%0t: %s expected %h actual %h", $realtime, field, want, got);
		errors++;
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;
	logic in_valid;
	logic in_ready;
	errb_pkg::in_beat_t in_data;
	logic out_valid;
	logic out_ready;
	errb_pkg::out_beat_t out_data;

	replay_scoreboard sb;
	int idle_cycles;

	episode_replay_ring_buffer u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Sample both handshakes at the rising edge; feed the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_beat(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog: stop when nothing moves for too long.
	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Receiver: random stall before taking each result beat.
	initial begin
		int gap;
		bit burst;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			burst = ($urandom_range(0, 7) == 0);
			gap = burst ? 0 : $urandom_range(0, 16);
			repeat (gap) @(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
			if (!burst || $urandom_range(0, 3) == 0)
				out_ready <= 1'b0;
		end
	end

	// Send one beat, after a random gap unless no_gap is set; hold until accepted.
	task automatic send_beat(input errb_pkg::in_beat_t b, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 16);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_push(input logic [3:0] who, input bit done, input bit no_gap);
		errb_pkg::in_beat_t b;
		b = '0;
		b.opcode = errb_pkg::OP_PUSH;
		b.agent = who;
		b.step_record = {$urandom, $urandom};
		b.action = 8'($urandom);
		b.done_req = done;
		b.episode_slot = 6'($urandom);
		b.step_index = 8'($urandom);
		send_beat(b, no_gap);
	endtask

	task automatic read_step(input logic [5:0] slot, input logic [7:0] idx, input bit no_gap);
		errb_pkg::in_beat_t b;
		b = '0;
		b.opcode = errb_pkg::OP_READ;
		b.agent = 4'($urandom);
		b.step_record = {$urandom, $urandom};
		b.action = 8'($urandom);
		b.done_req = 1'($urandom);
		b.episode_slot = slot;
		b.step_index = idx;
		send_beat(b, no_gap);
	endtask

	// Wait until every expected result has arrived, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(negedge clk);
		repeat (errb_pkg::MAX_STEPS + 8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random phase: mostly well-formed episodes, plus reads and noise.
	task automatic random_phase(input int items, input int max_len);
		int n, len;
		bit no_gap;
		n = 0;
		while (n < items) begin
			no_gap = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					// pushes to random agents, then a done push for a random agent
					len = $urandom_range(1, max_len);
					for (int i = 0; i < len; i++) begin
						send_push(4'($urandom), 1'b0, no_gap);
						n++;
					end
					send_push(4'($urandom_range(0, 15)), 1'b1, no_gap);
					n++;
				end
				5, 6, 7, 8: begin
					// reads of the valid region with an occasional overshoot
					read_step(6'($urandom), ($urandom_range(0, 7) == 0) ?
						8'($urandom) : 8'($urandom_range(0, max_len + 1)), no_gap);
					n++;
				end
				default: begin
					send_push(4'($urandom), $urandom_range(0, 3) == 0, no_gap);
					n++;
				end
			endcase
		end
	endtask

	initial begin
		sb = new();
		idle_cycles = 0;
		cfg_we = 1'b0;
		cfg_index = errb_pkg::REG_MAX_STEPS;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: short episode, a full episode, extremes, reads out of range.
		write_reg(errb_pkg::REG_MAX_STEPS, 9'd4);
		write_reg(errb_pkg::REG_SLOTS, 9'd3);
		write_reg(errb_pkg::REG_MIN_READY, 9'd2);
		send_push(4'd0, 1'b1, 1'b0);               // single-step done: no commit
		send_push(4'd15, 1'b0, 1'b0);
		send_push(4'd15, 1'b1, 1'b0);              // two-step episode commits
		for (int i = 0; i < 6; i++)
			send_push(4'd3, 1'b0, 1'b1);           // four stored, the rest past the limit dropped
		send_push(4'd3, 1'b1, 1'b1);               // done on a full store
		read_step(6'd0, 8'd0, 1'b0);
		read_step(6'd0, 8'd1, 1'b0);
		read_step(6'd0, 8'd2, 1'b0);               // beyond the episode length
		read_step(6'd1, 8'd3, 1'b0);
		read_step(6'd63, 8'd255, 1'b0);            // never filled slot
		for (int i = 0; i < 3; i++) begin
			send_push(4'd7, 1'b0, 1'b1);
			send_push(4'd7, 1'b1, 1'b1);           // wraps head at three slots
		end
		read_step(6'd2, 8'd1, 1'b0);
		drain();

		// Sweep register settings, the extremes among them.
		write_reg(errb_pkg::REG_MAX_STEPS, 9'd1);  // nothing can commit
		write_reg(errb_pkg::REG_SLOTS, 9'd0);
		write_reg(errb_pkg::REG_MIN_READY, 9'd0);
		random_phase(60, 4);
		drain();
		write_reg(errb_pkg::REG_MAX_STEPS, 9'd2);
		write_reg(errb_pkg::REG_SLOTS, 9'd1);
		write_reg(errb_pkg::REG_MIN_READY, 9'd64);
		random_phase(150, 4);
		drain();
		write_reg(errb_pkg::REG_MAX_STEPS, 9'd511); // saturates at MAX_STEPS
		write_reg(errb_pkg::REG_SLOTS, 9'd127);     // saturates at EPISODES
		write_reg(errb_pkg::REG_MIN_READY, 9'd127);
		random_phase(250, 8);
		drain();
		write_reg(errb_pkg::REG_MAX_STEPS, 9'd256);
		for (int i = 0; i < 257; i++)
			send_push(4'd9, i == 256, 1'b1);       // full-length episode
		read_step(6'd0, 8'd255, 1'b0);
		drain();
		write_reg(errb_pkg::REG_MAX_STEPS, 9'd12);
		write_reg(errb_pkg::REG_SLOTS, 9'd5);      // lowered slot count
		write_reg(errb_pkg::REG_MIN_READY, 9'd3);
		random_phase(300, 14);
		drain();
		write_reg(errb_pkg::REG_MAX_STEPS, 9'd30);
		write_reg(errb_pkg::REG_SLOTS, 9'd64);
		write_reg(errb_pkg::REG_MIN_READY, 9'd1);
		random_phase(250, 10);
		drain();
		write_reg(errb_pkg::REG_SLOTS, 9'd17);
		random_phase(250, 6);

		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(negedge clk);
		repeat (errb_pkg::MAX_STEPS + 8) @(negedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

`default_nettype wire
